### hdl/swcg_pkg.sv
`default_nettype none

package swcg_pkg;

   // largest usable grid side
   localparam int MAX_DIM   = 128;

   // fixed field widths
   localparam int DIM_W     = 8;
   localparam int CRD_W     = 7;
   localparam int POS_W     = 10;
   localparam int TOT_W     = 2 * DIM_W;

   // leg lengths reach 2*MAX_DIM+3 just after the last ring turn
   localparam int LEG_LIMIT = 2 * MAX_DIM + 1;
   localparam int LEG_W     = $clog2(2 * MAX_DIM + 4);
   localparam int CNT_W     = $clog2(MAX_DIM * MAX_DIM + 1);

   typedef enum logic [1:0] {
      REG_GRID_ROWS = 2'd0,
      REG_GRID_COLS = 2'd1,
      REG_START_ROW = 2'd2,
      REG_START_COL = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      HEAD_EAST  = 2'd0,
      HEAD_SOUTH = 2'd1,
      HEAD_WEST  = 2'd2,
      HEAD_NORTH = 2'd3
   } heading_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_WALK = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic start_walk;
      logic step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic active;
      logic guard;
      logic next_in_grid;
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

### hdl/swcg_ctrl.sv
`default_nettype none

module swcg_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_restart,
   input  wire swcg_pkg::dp_sts_type sts,
   output swcg_pkg::dp_cmd_type    cmd
);
   import swcg_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          restart_ff, restart_in;
   logic          accept;

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= CTL_IDLE;
         restart_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         restart_ff <= restart_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      restart_in = restart_ff;
      req_stall  = 1'b1;
      cmd        = '0;
      case (state_ff)
         CTL_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               restart_in = req_restart;
               state_in   = CTL_WALK;
            end
         end
         CTL_WALK: begin
            if (restart_ff || !sts.active || sts.guard) begin
               // fresh walk: the start cell is the result
               if (sts.out_free) begin
                  cmd.start_walk = 1'b1;
                  cmd.emit       = 1'b1;
                  state_in       = CTL_IDLE;
               end
            end else if (sts.next_in_grid) begin
               if (sts.out_free) begin
                  cmd.step = 1'b1;
                  cmd.emit = 1'b1;
                  state_in = CTL_IDLE;
               end
            end else begin
               // off-grid spiral position, step over it
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hdl/swcg_datapath.sv
`default_nettype none

module swcg_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire swcg_pkg::csr_index_type       csr_index,
   input  wire logic [swcg_pkg::DIM_W-1:0]    csr_wdata,
   input  wire swcg_pkg::dp_cmd_type          cmd,
   output swcg_pkg::dp_sts_type               sts,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [swcg_pkg::CRD_W-1:0]         rsp_cell_row,
   output logic [swcg_pkg::CRD_W-1:0]         rsp_cell_col,
   output logic                               rsp_last_cell
);
   import swcg_pkg::*;

   logic [DIM_W-1:0]        grid_rows_ff, grid_cols_ff;
   logic [CRD_W-1:0]        start_row_ff, start_col_ff;

   logic signed [POS_W-1:0] walk_row_ff, walk_row_in;
   logic signed [POS_W-1:0] walk_col_ff, walk_col_in;
   heading_type             heading_ff, heading_in;
   logic [LEG_W-1:0]        leg_base_ff, leg_base_in;
   logic [LEG_W-1:0]        leg_step_ff, leg_step_in;
   logic [CNT_W-1:0]        emitted_ff, emitted_in;
   logic                    active_ff, active_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CRD_W-1:0]        out_row_ff, out_row_in;
   logic [CRD_W-1:0]        out_col_ff, out_col_in;
   logic                    out_last_ff, out_last_in;

   logic [DIM_W-1:0]        rows, cols;
   logic [TOT_W-1:0]        total;
   logic [CRD_W-1:0]        first_row, first_col;
   logic signed [POS_W-1:0] next_row, next_col;
   logic [LEG_W-1:0]        leg_len, step_cnt;
   logic [CNT_W-1:0]        emitted_nx;
   logic                    last_nx;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= DIM_W'(1);
         grid_cols_ff <= DIM_W'(1);
         start_row_ff <= '0;
         start_col_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_GRID_ROWS: grid_rows_ff <= csr_wdata;
            REG_GRID_COLS: grid_cols_ff <= csr_wdata;
            REG_START_ROW: start_row_ff <= csr_wdata[CRD_W-1:0];
            REG_START_COL: start_col_ff <= csr_wdata[CRD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // zero reads as one, oversize saturates
   always_comb begin
      rows = grid_rows_ff;
      if (grid_rows_ff == '0)
         rows = DIM_W'(1);
      else if (grid_rows_ff > DIM_W'(MAX_DIM))
         rows = DIM_W'(MAX_DIM);
      cols = grid_cols_ff;
      if (grid_cols_ff == '0)
         cols = DIM_W'(1);
      else if (grid_cols_ff > DIM_W'(MAX_DIM))
         cols = DIM_W'(MAX_DIM);
   end

   assign total = TOT_W'(rows) * TOT_W'(cols);

   always_comb begin
      first_row = ({1'b0, start_row_ff} < rows) ? start_row_ff : CRD_W'(rows - DIM_W'(1));
      first_col = ({1'b0, start_col_ff} < cols) ? start_col_ff : CRD_W'(cols - DIM_W'(1));
   end

   // one spiral step
   always_comb begin
      next_row = walk_row_ff;
      next_col = walk_col_ff;
      case (heading_ff)
         HEAD_EAST:  next_col = walk_col_ff + POS_W'(1);
         HEAD_SOUTH: next_row = walk_row_ff + POS_W'(1);
         HEAD_WEST:  next_col = walk_col_ff - POS_W'(1);
         HEAD_NORTH: next_row = walk_row_ff - POS_W'(1);
         default: begin
         end
      endcase
   end

   assign leg_len  = leg_base_ff + LEG_W'(heading_ff[1]);
   assign step_cnt = leg_step_ff + LEG_W'(1);

   assign emitted_nx = cmd.start_walk ? CNT_W'(1) : emitted_ff + CNT_W'(1);
   assign last_nx    = TOT_W'(emitted_nx) >= total;

   always_comb begin
      walk_row_in  = walk_row_ff;
      walk_col_in  = walk_col_ff;
      heading_in   = heading_ff;
      leg_base_in  = leg_base_ff;
      leg_step_in  = leg_step_ff;
      emitted_in   = emitted_ff;
      active_in    = active_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_last_in  = out_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.start_walk) begin
         walk_row_in = POS_W'(first_row);
         walk_col_in = POS_W'(first_col);
         heading_in  = HEAD_EAST;
         leg_base_in = LEG_W'(1);
         leg_step_in = '0;
      end else if (cmd.step) begin
         walk_row_in = next_row;
         walk_col_in = next_col;
         leg_step_in = step_cnt;
         if (step_cnt >= leg_len) begin
            leg_step_in = '0;
            heading_in  = heading_type'(heading_ff + 2'd1);
            if (heading_ff == HEAD_NORTH)
               leg_base_in = leg_base_ff + LEG_W'(2);
         end
      end

      if (cmd.emit) begin
         emitted_in   = emitted_nx;
         active_in    = !last_nx;
         out_last_in  = last_nx;
         out_row_in   = walk_row_in[CRD_W-1:0];
         out_col_in   = walk_col_in[CRD_W-1:0];
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_row_ff  <= '0;
         walk_col_ff  <= '0;
         heading_ff   <= HEAD_EAST;
         leg_base_ff  <= LEG_W'(1);
         leg_step_ff  <= '0;
         emitted_ff   <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         walk_row_ff  <= walk_row_in;
         walk_col_ff  <= walk_col_in;
         heading_ff   <= heading_in;
         leg_base_ff  <= leg_base_in;
         leg_step_ff  <= leg_step_in;
         emitted_ff   <= emitted_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      sts.active       = active_ff;
      sts.guard        = leg_base_ff > LEG_W'(LEG_LIMIT);
      sts.next_in_grid = !next_row[POS_W-1] && !next_col[POS_W-1] &&
                         (next_row[POS_W-2:0] < (POS_W-1)'(rows)) &&
                         (next_col[POS_W-2:0] < (POS_W-1)'(cols));
      sts.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_row  = out_row_ff;
   assign rsp_cell_col  = out_col_ff;
   assign rsp_last_cell = out_last_ff;

endmodule

`default_nettype wire

### hdl/spiral_walk_coordinate_generator_unit.sv
// channel | ports                                   | direction | moves
// req     | req_valid, req_stall, req_restart       | in        | one request transaction
// rsp     | rsp_valid, rsp_stall, rsp_cell_row/col, | out       | one cell transaction
//         | rsp_last_cell                           |           |
// csr     | csr_wr_en, csr_index, csr_wdata         | in        | register write
//
// a request is accepted while idle; the walk then steps over off-grid spiral
// positions until it reaches the next in-grid cell (the start cell for a
// fresh start); the spiral steps are set by the single step unit
// reset is synchronous and active high; it returns the registers to a 1x1
// grid at cell 0,0 and makes the next request start a fresh walk
// a pending result waits in the output register; the walk holds before
// emitting while rsp_stall keeps that register full
`default_nettype none

module spiral_walk_coordinate_generator_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // configuration
   input  wire logic                       csr_wr_en,
   input  wire swcg_pkg::csr_index_type    csr_index,
   input  wire logic [swcg_pkg::DIM_W-1:0] csr_wdata,
   // request channel
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_restart,
   // result channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [swcg_pkg::CRD_W-1:0]      rsp_cell_row,
   output logic [swcg_pkg::CRD_W-1:0]      rsp_cell_col,
   output logic                            rsp_last_cell
);
   import swcg_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer: accepts a request, then walks until a cell can be emitted
   swcg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .sts         (sts),
      .cmd         (cmd)
   );

   // walk position, leg counters, config registers and output register
   swcg_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cell_row  (rsp_cell_row),
      .rsp_cell_col  (rsp_cell_col),
      .rsp_last_cell (rsp_last_cell)
   );

`ifndef SYNTHESIS
   // a cell is only loaded when the output register can take it
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("cell emitted into a full output register");

   // a fresh start and a spiral step never happen together
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.start_walk && cmd.step))
      else $error("start and step commanded together");

   // one request at a time: the input closes right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one in progress");

   // an emitted cell shows up on the result channel next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emitted cell not presented");
`endif

endmodule

`default_nettype wire
